### sv/lpm_pkg.sv
// Package for the IPv4 longest-prefix-match table: item types, codes and the
// prefix mask function. Used by lpm_cell, ipv4_longest_prefix_match_table and the bench.
`default_nettype none

package lpm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned HOP_WIDTH_DEF   = 8;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned HOP_FIELD_W = 8;
  localparam int unsigned CNT_FIELD_W = 5;

  localparam logic [LEN_W-1:0] MAX_PREFIX = LEN_W'(ADDR_W);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_PREFIX = 2'd2;

  typedef struct packed {
    logic [1:0]             command;
    logic [ADDR_W-1:0]      address;
    logic [LEN_W-1:0]       prefix_len;
    logic [HOP_FIELD_W-1:0] next_hop;
  } lpm_req_t;

  typedef struct packed {
    logic                   hit;
    logic [HOP_FIELD_W-1:0] hop_out;
    logic [LEN_W-1:0]       match_len;
    logic [1:0]             status;
    logic [CNT_FIELD_W-1:0] entry_count;
  } lpm_rsp_t;

  // Item as it walks along the cell row, with the best match found so far.
  typedef struct packed {
    lpm_req_t               req;
    logic                   hit;
    logic [LEN_W-1:0]       best_len;
    logic [HOP_FIELD_W-1:0] best_hop;
    logic                   dup;
  } lpm_tok_t;

  // Broadcast to every cell when an item completes.
  typedef struct packed {
    logic                   clear;
    logic [ADDR_W-1:0]      address;
    logic [LEN_W-1:0]       prefix_len;
    logic [HOP_FIELD_W-1:0] next_hop;
  } lpm_cmt_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= MAX_PREFIX) begin
      m = '1;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_PREFIX - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### sv/ipv4_longest_prefix_match_table.sv
// Top level of the IPv4 longest-prefix-match table: the row of route cells,
// the completion stage and the result register. Depends on lpm_pkg, lpm_cell.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (lpm_req_t)
//   out      output     out_valid_o / out_stall_i out_data_o (lpm_rsp_t)
//
// An item walks the row of TABLE_DEPTH cells, one cell a cycle, and then
// completes from the hold register; one item is in the row at a time, so a new
// item is taken only once the last one has completed.
// A stalled result holds completion of the next item, not its walk.
// Reset empties the table at once; there is no clearing pass.
`default_nettype none

module ipv4_longest_prefix_match_table import lpm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned HOP_WIDTH   = HOP_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lpm_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lpm_rsp_t      out_data_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [TABLE_DEPTH:0] tok_vld;
  lpm_tok_t             tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0] free_f;
  logic [IDX_W-1:0]     free_idx [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] slot_vld;
  logic [TABLE_DEPTH-1:0] wr_en;

  logic             busy_q;
  logic             pend_q;
  lpm_tok_t         hold_q;
  logic             hold_free_q;
  logic [IDX_W-1:0] hold_idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  lpm_rsp_t         rsp_d;
  lpm_cmt_t         cmt;
  logic             in_acc;
  logic             go;
  logic             len_ok;
  logic             do_wr;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  assign tok_vld[0]  = in_acc;
  assign tok[0]      = '{req: in_data_i, hit: 1'b0, best_len: '0, best_hop: '0, dup: 1'b0};
  assign free_f[0]   = 1'b0;
  assign free_idx[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign wr_en[i] = do_wr && (hold_idx_q == IDX_W'(i));
    lpm_cell #(
      .HOP_WIDTH (HOP_WIDTH),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_vld_i  (tok_vld[i]),
      .tok_i      (tok[i]),
      .free_i     (free_f[i]),
      .free_idx_i (free_idx[i]),
      .wr_i       (wr_en[i]),
      .cmt_i      (cmt),
      .tok_vld_o  (tok_vld[i+1]),
      .tok_o      (tok[i+1]),
      .free_o     (free_f[i+1]),
      .free_idx_o (free_idx[i+1]),
      .slot_vld_o (slot_vld[i])
    );
  end

  always_comb begin
    go     = pend_q && (!out_valid_o || !out_stall_i);
    len_ok = hold_q.req.prefix_len <= MAX_PREFIX;
    do_wr  = go && (hold_q.req.command == CMD_INSERT) && len_ok &&
             !hold_q.dup && hold_free_q;

    cmt.clear      = go && (hold_q.req.command == CMD_CLEAR);
    cmt.address    = hold_q.req.address;
    cmt.prefix_len = hold_q.req.prefix_len;
    cmt.next_hop   = hold_q.req.next_hop;

    cnt_d = cnt_q;
    if (cmt.clear) begin
      cnt_d = '0;
    end else if (do_wr) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    rsp_d.hit         = hold_q.hit;
    rsp_d.hop_out     = hold_q.best_hop;
    rsp_d.match_len   = hold_q.best_len;
    rsp_d.status      = ST_OK;
    rsp_d.entry_count = CNT_FIELD_W'(cnt_d);
    if (hold_q.req.command == CMD_INSERT) begin
      if (!len_ok) begin
        rsp_d.status = ST_PREFIX;
      end else if (!hold_q.dup && !hold_free_q) begin
        rsp_d.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (go) begin
        busy_q <= 1'b0;
      end
      if (tok_vld[TABLE_DEPTH]) begin
        pend_q <= 1'b1;
      end else if (go) begin
        pend_q <= 1'b0;
      end
      if (go) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld[TABLE_DEPTH]) begin
      hold_q      <= tok[TABLE_DEPTH];
      hold_free_q <= free_f[TABLE_DEPTH];
      hold_idx_q  <= free_idx[TABLE_DEPTH];
    end
    if (go) begin
      out_data_o <= rsp_d;
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({tok_vld[TABLE_DEPTH:1], pend_q}) <= 1)
    else $error("more than one item inside the table");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_vld) == int'(cnt_q))
    else $error("route count differs from the number of valid slots");

  a_done_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (out_valid_o && !pend_q))
    else $error("completed item did not reach the result register");

  a_busy_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q || (|tok_vld[TABLE_DEPTH:1])) |-> busy_q)
    else $error("input accepted while an item is still inside the table");

endmodule

`default_nettype wire

### sv/lpm_cell.sv
// One route slot of the table and the item register that follows it.
// Depends on lpm_pkg.
`default_nettype none

module lpm_cell import lpm_pkg::*; #(
  parameter int unsigned HOP_WIDTH = HOP_WIDTH_DEF,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tok_vld_i,
  input  wire lpm_tok_t         tok_i,
  input  wire logic             free_i,
  input  wire logic [IDX_W-1:0] free_idx_i,
  input  wire logic             wr_i,
  input  wire lpm_cmt_t         cmt_i,
  output logic                  tok_vld_o,
  output lpm_tok_t              tok_o,
  output logic                  free_o,
  output logic [IDX_W-1:0]      free_idx_o,
  output logic                  slot_vld_o
);

  logic                 valid_q;
  logic [ADDR_W-1:0]    net_q;
  logic [LEN_W-1:0]     len_q;
  logic [HOP_WIDTH-1:0] hop_q;

  logic [ADDR_W-1:0] mask;
  logic              match;
  logic              dup_hit;
  lpm_tok_t          tok_d;
  logic              free_d;
  logic [IDX_W-1:0]  free_idx_d;

  always_comb begin
    mask    = prefix_mask(len_q);
    match   = valid_q && ((tok_i.req.address & mask) == (net_q & mask));
    dup_hit = tok_vld_i && (tok_i.req.command == CMD_INSERT) && valid_q &&
              (tok_i.req.prefix_len <= MAX_PREFIX) &&
              (net_q == tok_i.req.address) && (len_q == tok_i.req.prefix_len);
    tok_d = tok_i;
    if ((tok_i.req.command == CMD_LOOKUP) && match &&
        (!tok_i.hit || (len_q > tok_i.best_len))) begin
      tok_d.hit      = 1'b1;
      tok_d.best_len = len_q;
      tok_d.best_hop = HOP_FIELD_W'(hop_q);
    end
    if (dup_hit) begin
      tok_d.dup = 1'b1;
    end
    free_d     = free_i;
    free_idx_d = free_idx_i;
    if (!valid_q && !free_i) begin
      free_d     = 1'b1;
      free_idx_d = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_o <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      tok_vld_o <= tok_vld_i;
      if (cmt_i.clear) begin
        valid_q <= 1'b0;
      end else if (wr_i) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      tok_o      <= tok_d;
      free_o     <= free_d;
      free_idx_o <= free_idx_d;
    end
    if (wr_i) begin
      net_q <= cmt_i.address;
      len_q <= cmt_i.prefix_len;
      hop_q <= HOP_WIDTH'(cmt_i.next_hop);
    end else if (dup_hit) begin
      hop_q <= HOP_WIDTH'(tok_i.req.next_hop);
    end
  end

  assign slot_vld_o = valid_q;

endmodule

`default_nettype wire

### bench/lpm_route_checker.sv
// Checker for the IPv4 longest-prefix-match table: watches both channels, keeps
// its own copy of the route table to predict each result and compares field by
// field. Depends on lpm_pkg.
`timescale 1ns / 1ps

module lpm_route_checker import lpm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_stall_i,
  input  wire lpm_req_t in_data_i,
  input  wire logic     out_valid_i,
  input  wire logic     out_stall_i,
  input  wire lpm_rsp_t out_data_i,
  output int            err_count_o,
  output int            pending_o
);

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  logic                   route_valid [DEPTH];
  logic [ADDR_W-1:0]      route_net   [DEPTH];
  logic [LEN_W-1:0]       route_len   [DEPTH];
  logic [HOP_FIELD_W-1:0] route_hop   [DEPTH];
  logic [CNT_FIELD_W-1:0] route_total;

  lpm_rsp_t awaited_rsp_q[$];
  int       errors = 0;

  assign err_count_o = errors;
  assign pending_o   = awaited_rsp_q.size();

  task automatic report(input string msg);
    errors++;
    $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  function automatic lpm_rsp_t route_result(input lpm_req_t r);
    lpm_rsp_t          rsp;
    logic [ADDR_W-1:0] m;
    int                free_idx;
    logic              dup;
    rsp = '0;
    free_idx = -1;
    dup = 1'b0;
    case (r.command)
      CMD_LOOKUP: begin
        for (int i = 0; i < DEPTH; i++) begin
          m = ~({ADDR_W{1'b1}} >> route_len[i]);
          if (route_valid[i] && ((r.address & m) == (route_net[i] & m)) &&
              (!rsp.hit || route_len[i] > rsp.match_len)) begin
            rsp.hit = 1'b1;
            rsp.match_len = route_len[i];
            rsp.hop_out = route_hop[i];
          end
        end
      end
      CMD_INSERT: begin
        if (r.prefix_len > MAX_PREFIX) begin
          rsp.status = ST_PREFIX;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (route_valid[i]) begin
              if (!dup && route_net[i] == r.address && route_len[i] == r.prefix_len) begin
                route_hop[i] = r.next_hop;
                dup = 1'b1;
              end
            end else if (free_idx < 0) begin
              free_idx = i;
            end
          end
          if (!dup) begin
            if (free_idx < 0) begin
              rsp.status = ST_FULL;
            end else begin
              route_valid[free_idx] = 1'b1;
              route_net[free_idx] = r.address;
              route_len[free_idx] = r.prefix_len;
              route_hop[free_idx] = r.next_hop;
              route_total = route_total + 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) begin
          route_valid[i] = 1'b0;
        end
        route_total = '0;
      end
      default: begin
      end
    endcase
    rsp.entry_count = route_total;
    return rsp;
  endfunction

  task automatic compare_result(input lpm_rsp_t got);
    lpm_rsp_t want;
    if (awaited_rsp_q.size() == 0) begin
      report($sformatf("result %h arrived with nothing expected", got));
    end else begin
      want = awaited_rsp_q.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit: expected %0h, got %0h", want.hit, got.hit));
      if (got.hop_out !== want.hop_out)
        report($sformatf("hop_out: expected %0h, got %0h", want.hop_out, got.hop_out));
      if (got.match_len !== want.match_len)
        report($sformatf("match_len: expected %0d, got %0d", want.match_len, got.match_len));
      if (got.status !== want.status)
        report($sformatf("status: expected %0d, got %0d", want.status, got.status));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count: expected %0d, got %0d", want.entry_count,
                         got.entry_count));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        route_valid[i] = 1'b0;
      end
      route_total = '0;
      awaited_rsp_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        compare_result(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_rsp_q.push_back(route_result(in_data_i));
      end
    end
  end

endmodule

### bench/tb.sv
// Top of the bench for the IPv4 longest-prefix-match table: clock, reset and
// stimulus with random idling on both sides, and the final verdict.
// Depends on lpm_pkg, lpm_route_checker and ipv4_longest_prefix_match_table.
`timescale 1ns / 1ps

module tb import lpm_pkg::*;;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1930;
  localparam int         CHUNKS       = 8;
  localparam int         LIMIT        = 600000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  lpm_req_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lpm_rsp_t out_data_o;

  int failures;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  lpm_req_t known_routes[$];

  always #2 clk_i = ~clk_i;

  ipv4_longest_prefix_match_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  lpm_route_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .err_count_o (failures),
    .pending_o   (pending)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles", LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic lpm_req_t make_req(input logic [1:0] cmd, input logic [31:0] addr,
                                        input logic [5:0] len, input logic [7:0] hop);
    lpm_req_t r;
    r.command = cmd;
    r.address = addr;
    r.prefix_len = len;
    r.next_hop = hop;
    return r;
  endfunction

  task automatic send_item(input lpm_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    if (r.command == CMD_INSERT && r.prefix_len <= MAX_PREFIX) begin
      known_routes.push_back(r);
      if (known_routes.size() > 48) begin
        void'(known_routes.pop_front());
      end
    end
  endtask

  function automatic lpm_req_t random_item();
    lpm_req_t    r;
    lpm_req_t    k;
    logic [31:0] m;
    int          sel;
    r = make_req(CMD_LOOKUP, $urandom, 6'($urandom_range(0, 63)), 8'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      r.command = CMD_CLEAR;
    end else if (sel < 5) begin
      r.command = CMD_UNUSED;
    end else if (sel < 50) begin
      if (known_routes.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = known_routes[$urandom_range(0, known_routes.size() - 1)];
        m = ~(32'hFFFF_FFFF >> k.prefix_len);
        r.address = (k.address & m) | ($urandom & ~m);
      end
    end else begin
      r.command = CMD_INSERT;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        r.prefix_len = 6'($urandom_range(33, 63));
      end else if (known_routes.size() != 0 && sel < 6) begin
        k = known_routes[$urandom_range(0, known_routes.size() - 1)];
        r.address = k.address;
        r.prefix_len = (sel < 3) ? k.prefix_len : 6'($urandom_range(0, 32));
      end else begin
        r.prefix_len = 6'($urandom_range(0, 32));
      end
    end
    return r;
  endfunction

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(make_req(CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00));
    send_item(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'hFF));
    send_item(make_req(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF));
    send_item(make_req(CMD_INSERT, 32'h0000_0000, 6'd0, 8'h01));
    send_item(make_req(CMD_INSERT, 32'hC0A8_0000, 6'd33, 8'h5A));
    send_item(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00));
    send_item(make_req(CMD_LOOKUP, 32'h1234_5678, 6'd0, 8'h00));
    send_item(make_req(CMD_INSERT, 32'h0000_0000, 6'd0, 8'hAA));
    send_item(make_req(CMD_LOOKUP, 32'h1234_5678, 6'd0, 8'h00));
    send_item(make_req(CMD_INSERT, 32'h0A00_0001, 6'd8, 8'h11));
    send_item(make_req(CMD_INSERT, 32'h0A00_0002, 6'd8, 8'h22));
    send_item(make_req(CMD_LOOKUP, 32'h0A7F_0000, 6'd0, 8'h00));
    for (int i = 0; i < 13; i++) begin
      send_item(make_req(CMD_INSERT, {16'hC0A8, 8'(i), 8'h00}, 6'd24, 8'(i)));
    end
    send_item(make_req(CMD_INSERT, 32'h0A00_0001, 6'd8, 8'h33));
    send_item(make_req(CMD_LOOKUP, 32'h0A00_0001, 6'd0, 8'h00));
    send_item(make_req(CMD_CLEAR, 32'h0000_0000, 6'd0, 8'h00));

    for (int c = 0; c < CHUNKS; c++) begin
      case (c % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 61;
        end
        default: begin
          idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      if (c == 3) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) begin
          @(negedge clk_i);
        end
      end
      for (int n = 0; n < RANDOM_ITEMS / CHUNKS; n++) begin
        send_item(random_item());
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (40) @(negedge clk_i);
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### ipv4_longest_prefix_match_table.f
sv/lpm_pkg.sv
sv/lpm_cell.sv
sv/ipv4_longest_prefix_match_table.sv
bench/lpm_route_checker.sv
bench/tb.sv
